/* src/lidar_point_range_decimation_filter_defines.svh */
// assertion macros shared by the lidar point filter modules
// no dependencies; included by files that carry assertions
`ifndef LIDAR_POINT_RANGE_DECIMATION_FILTER_DEFINES_SVH
`define LIDAR_POINT_RANGE_DECIMATION_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define LPF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpf assertion failed");
`define LPF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpf assertion failed");
`else
`define LPF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/lpf_pkg.sv */
// types and constants for the lidar point range and decimation filter
// no dependencies
package lpf_pkg;

   localparam int REG_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;
   localparam int MODE_BITS      = 2;
   localparam int DEC_BITS       = 8;
   localparam int BLIND_BITS     = 48;
   localparam int LINE_BITS      = 8;
   localparam int TIME_BITS      = 32;
   localparam int REFLECT_BITS   = 8;
   localparam int RING_BITS      = 8;
   localparam int TAG_BITS       = 8;
   localparam int COUNT_BITS     = 32;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_SENSOR_MODE    = 3'd0,
      REG_DECIMATION     = 3'd1,
      REG_BLIND_RANGE_SQ = 3'd2,
      REG_LINE_COUNT     = 3'd3,
      REG_TIME_MULT      = 3'd4
   } reg_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TAGGED  = 2'd0,
      MODE_SPIN_64 = 2'd1,
      MODE_SPIN_16 = 2'd2
   } mode_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  sensor_mode;
      logic [DEC_BITS-1:0]   decimation;
      logic [BLIND_BITS-1:0] blind_range_sq;
      logic [LINE_BITS-1:0]  line_count;
      logic [TIME_BITS-1:0]  time_mult;
   } cfg_type;

   localparam logic [MODE_BITS-1:0]  RST_SENSOR_MODE = MODE_TAGGED;
   localparam logic [DEC_BITS-1:0]   RST_DECIMATION  = 8'd1;
   localparam logic [BLIND_BITS-1:0] RST_BLIND       = 48'd100;
   localparam logic [LINE_BITS-1:0]  RST_LINE_COUNT  = 8'd6;
   localparam logic [TIME_BITS-1:0]  RST_TIME_MULT   = 32'd281475;

   // class given to a point by the front end
   typedef enum logic [1:0] {
      CLS_DROP    = 2'd0,
      CLS_TAGGED  = 2'd1,
      CLS_SPIN_GE = 2'd2,
      CLS_SPIN_GT = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type cls;
      logic    differs;
      logic    frame_start;
   } ctl_type;

   localparam logic [TAG_BITS-1:0]  KIND_MASK   = 8'h30;
   localparam logic [TAG_BITS-1:0]  KIND_STRONG = 8'h10;
   localparam logic [TAG_BITS-1:0]  KIND_SINGLE = 8'h00;
   localparam logic [TIME_BITS-1:0] TIME_LIMIT  = 32'h0064_0000;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam int RES_STEPS     = COUNT_BITS;
   localparam int RES_STEP_BITS = 5;

endpackage

/* src/lpf_queue.sv */
// short word queue between the classifying front end and the back end
// depends on lpf_pkg and the assertion macro header
`include "lidar_point_range_decimation_filter_defines.svh"
module lpf_queue #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   output logic [DATA_BITS-1:0] rd_data,
   output logic                 full,
   output logic                 empty
);

   logic [DATA_BITS-1:0]              mem_ff [lpf_pkg::QUEUE_DEPTH];
   logic [lpf_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lpf_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lpf_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                               do_wr, do_rd;

   assign full    = (count_ff == (lpf_pkg::QUEUE_PTR_BITS+1)'(lpf_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `LPF_ASSERT_NXT(a_count_up, clock, reset, do_wr && !do_rd, count_ff == $past(count_ff) + 1'b1)

endmodule

/* src/lpf_front.sv */
// front end: frame counters, decimation residues and point classification
// depends on lpf_pkg and the assertion macro header
`include "lidar_point_range_decimation_filter_defines.svh"
module lpf_front #(
   parameter int COORD_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lpf_pkg::cfg_type                 cfg,
   input  logic                             dec_load,
   input  logic                             accept,
   input  logic                             frame_start,
   input  logic signed [COORD_BITS-1:0]     pos_x,
   input  logic signed [COORD_BITS-1:0]     pos_y,
   input  logic signed [COORD_BITS-1:0]     pos_z,
   input  logic [lpf_pkg::RING_BITS-1:0]    ring,
   input  logic [lpf_pkg::TAG_BITS-1:0]     tag,
   output logic                             busy,
   output lpf_pkg::ctl_type                 ctl
);

   logic [lpf_pkg::COUNT_BITS-1:0] point_index_ff, point_index_in;
   logic [lpf_pkg::COUNT_BITS-1:0] valid_count_ff, valid_count_in;
   logic [lpf_pkg::DEC_BITS-1:0]   idx_res_ff, idx_res_in;
   logic [lpf_pkg::DEC_BITS-1:0]   vc_res_ff, vc_res_in;
   logic signed [COORD_BITS-1:0]   prev_x_ff, prev_x_in;
   logic signed [COORD_BITS-1:0]   prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0]   prev_z_ff, prev_z_in;
   logic                           busy_ff, busy_in;
   logic [lpf_pkg::RES_STEP_BITS-1:0] step_ff, step_in;
   logic [lpf_pkg::COUNT_BITS-1:0] idx_src_ff, idx_src_in;
   logic [lpf_pkg::COUNT_BITS-1:0] vc_src_ff, vc_src_in;

   logic [lpf_pkg::DEC_BITS-1:0]   dec_eff;
   logic [lpf_pkg::COUNT_BITS-1:0] idx, vc;
   logic [lpf_pkg::DEC_BITS-1:0]   idx_res, vc_res, idx_res_inc, vc_res_inc;
   logic [lpf_pkg::DEC_BITS-1:0]   idx_res_next, vc_res_next;
   logic signed [COORD_BITS-1:0]   prev_x, prev_y, prev_z;
   logic [lpf_pkg::TAG_BITS-1:0]   kind;
   logic                           qual, stored, spin;

   // one restoring step of a remainder by the decimation factor
   function automatic logic [lpf_pkg::DEC_BITS-1:0] mod_step(
      input logic [lpf_pkg::DEC_BITS-1:0] rem,
      input logic                         din,
      input logic [lpf_pkg::DEC_BITS-1:0] d
   );
      logic [lpf_pkg::DEC_BITS:0] t;
      t = {rem, din};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[lpf_pkg::DEC_BITS-1:0];
   endfunction

   assign dec_eff = (cfg.decimation == '0) ? lpf_pkg::DEC_BITS'(1) : cfg.decimation;
   assign busy    = busy_ff;

   // frame start clears the state before the point is looked at
   assign idx     = frame_start ? '0 : point_index_ff;
   assign vc      = frame_start ? '0 : valid_count_ff;
   assign idx_res = frame_start ? '0 : idx_res_ff;
   assign vc_res  = frame_start ? '0 : vc_res_ff;
   assign prev_x  = frame_start ? '0 : prev_x_ff;
   assign prev_y  = frame_start ? '0 : prev_y_ff;
   assign prev_z  = frame_start ? '0 : prev_z_ff;

   assign idx_res_inc  = idx_res + 1'b1;
   assign vc_res_inc   = vc_res + 1'b1;
   assign idx_res_next = ((&idx) || (idx_res_inc == dec_eff)) ? '0 : idx_res_inc;
   assign vc_res_next  = ((&vc) || (vc_res_inc == dec_eff)) ? '0 : vc_res_inc;

   assign kind   = tag & lpf_pkg::KIND_MASK;
   assign spin   = (cfg.sensor_mode == lpf_pkg::MODE_SPIN_64) ||
                   (cfg.sensor_mode == lpf_pkg::MODE_SPIN_16);
   assign qual   = (cfg.sensor_mode == lpf_pkg::MODE_TAGGED) && (idx != '0) &&
                   (ring < cfg.line_count) &&
                   ((kind == lpf_pkg::KIND_STRONG) || (kind == lpf_pkg::KIND_SINGLE));
   assign stored = qual && (vc_res_next == '0);

   always_comb begin
      ctl.differs     = (pos_x != prev_x) || (pos_y != prev_y) || (pos_z != prev_z);
      ctl.frame_start = frame_start;
      if (stored) begin
         ctl.cls = lpf_pkg::CLS_TAGGED;
      end else if (spin && (idx_res == '0)) begin
         ctl.cls = (cfg.sensor_mode == lpf_pkg::MODE_SPIN_64) ? lpf_pkg::CLS_SPIN_GE
                                                              : lpf_pkg::CLS_SPIN_GT;
      end else begin
         ctl.cls = lpf_pkg::CLS_DROP;
      end
   end

   always_comb begin
      point_index_in = point_index_ff;
      valid_count_in = valid_count_ff;
      idx_res_in     = idx_res_ff;
      vc_res_in      = vc_res_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      prev_z_in      = prev_z_ff;
      busy_in        = busy_ff;
      step_in        = step_ff;
      idx_src_in     = idx_src_ff;
      vc_src_in      = vc_src_ff;
      if (dec_load) begin
         // residues are rebuilt from the counters, one bit a cycle
         busy_in    = 1'b1;
         step_in    = '0;
         idx_src_in = point_index_ff;
         vc_src_in  = valid_count_ff;
         idx_res_in = '0;
         vc_res_in  = '0;
      end else if (busy_ff) begin
         idx_res_in = mod_step(idx_res_ff, idx_src_ff[lpf_pkg::COUNT_BITS-1], dec_eff);
         vc_res_in  = mod_step(vc_res_ff, vc_src_ff[lpf_pkg::COUNT_BITS-1], dec_eff);
         idx_src_in = idx_src_ff << 1;
         vc_src_in  = vc_src_ff << 1;
         step_in    = step_ff + 1'b1;
         if (step_ff == lpf_pkg::RES_STEP_BITS'(lpf_pkg::RES_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         point_index_in = idx + 1'b1;
         idx_res_in     = idx_res_next;
         valid_count_in = qual ? vc + 1'b1 : vc;
         vc_res_in      = qual ? vc_res_next : vc_res;
         prev_x_in      = stored ? pos_x : '0;
         prev_y_in      = stored ? pos_y : '0;
         prev_z_in      = stored ? pos_z : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_index_ff <= '0;
         valid_count_ff <= '0;
         idx_res_ff     <= '0;
         vc_res_ff      <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         prev_z_ff      <= '0;
         busy_ff        <= 1'b0;
         step_ff        <= '0;
      end else begin
         point_index_ff <= point_index_in;
         valid_count_ff <= valid_count_in;
         idx_res_ff     <= idx_res_in;
         vc_res_ff      <= vc_res_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         prev_z_ff      <= prev_z_in;
         busy_ff        <= busy_in;
         step_ff        <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_src_ff <= idx_src_in;
      vc_src_ff  <= vc_src_in;
   end

   `LPF_ASSERT_NXT(a_load_busy, clock, reset, dec_load, busy_ff)
   `LPF_ASSERT_IMP(a_res_bound, clock, reset, !busy_ff, (idx_res_ff < dec_eff) && (vc_res_ff < dec_eff))

endmodule

/* src/lpf_back.sv */
// back end: squares, time scaling, blind and time checks, frame maximum, result register
// depends on lpf_pkg and the assertion macro header
`include "lidar_point_range_decimation_filter_defines.svh"
module lpf_back #(
   parameter int COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lpf_pkg::cfg_type                  cfg,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  lpf_pkg::ctl_type                  q_ctl,
   input  logic signed [COORD_BITS-1:0]      q_x,
   input  logic signed [COORD_BITS-1:0]      q_y,
   input  logic signed [COORD_BITS-1:0]      q_z,
   input  logic [lpf_pkg::REFLECT_BITS-1:0]  q_reflect,
   input  logic [lpf_pkg::TIME_BITS-1:0]     q_raw_time,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [COORD_BITS-1:0]      out_x,
   output logic signed [COORD_BITS-1:0]      out_y,
   output logic signed [COORD_BITS-1:0]      out_z,
   output logic [lpf_pkg::REFLECT_BITS-1:0]  out_reflect,
   output logic [lpf_pkg::TIME_BITS-1:0]     time_ms,
   output logic [lpf_pkg::TIME_BITS-1:0]     max_time_ms
);

   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int R2_BITS   = SQ_BITS + 2;
   localparam int CMP_BITS  = (R2_BITS > lpf_pkg::BLIND_BITS) ? R2_BITS : lpf_pkg::BLIND_BITS;
   localparam int TP_BITS   = 2 * lpf_pkg::TIME_BITS;

   // stage 1: products
   logic                              s1_valid_ff, s1_valid_in;
   lpf_pkg::ctl_type                  s1_ctl_ff;
   logic signed [COORD_BITS-1:0]      s1_x_ff, s1_y_ff, s1_z_ff;
   logic [lpf_pkg::REFLECT_BITS-1:0]  s1_reflect_ff;
   logic [SQ_BITS-1:0]                s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   logic [lpf_pkg::TIME_BITS-1:0]     s1_t_ff;
   // stage 2: range sum
   logic                              s2_valid_ff;
   lpf_pkg::ctl_type                  s2_ctl_ff;
   logic signed [COORD_BITS-1:0]      s2_x_ff, s2_y_ff, s2_z_ff;
   logic [lpf_pkg::REFLECT_BITS-1:0]  s2_reflect_ff;
   logic [R2_BITS-1:0]                s2_r2_ff;
   logic [lpf_pkg::TIME_BITS-1:0]     s2_t_ff;
   // stage 3: result word
   logic                              s3_valid_ff, s3_valid_in;
   logic [lpf_pkg::TIME_BITS-1:0]     frame_max_ff, frame_max_in;
   logic signed [COORD_BITS-1:0]      s3_x_ff, s3_y_ff, s3_z_ff;
   logic [lpf_pkg::REFLECT_BITS-1:0]  s3_reflect_ff;
   logic [lpf_pkg::TIME_BITS-1:0]     s3_t_ff, s3_max_ff;

   logic                              adv, move;
   logic signed [SQ_BITS-1:0]         sqx, sqy, sqz;
   logic [TP_BITS-1:0]                tprod;
   logic [CMP_BITS-1:0]               r2c, blind_c;
   logic                              gt, ge, upd, emit;
   logic [lpf_pkg::TIME_BITS-1:0]     fm_base;

   assign adv   = !s3_valid_ff || pop;
   assign q_pop = adv && !q_empty;
   assign move  = adv && s2_valid_ff;
   assign empty = !s3_valid_ff;

   assign sqx   = q_x * q_x;
   assign sqy   = q_y * q_y;
   assign sqz   = q_z * q_z;
   assign tprod = TP_BITS'(q_raw_time) * TP_BITS'(cfg.time_mult);

   assign r2c     = CMP_BITS'(s2_r2_ff);
   assign blind_c = CMP_BITS'(cfg.blind_range_sq);
   assign gt      = r2c > blind_c;
   assign ge      = r2c >= blind_c;
   assign fm_base = s2_ctl_ff.frame_start ? '0 : frame_max_ff;

   always_comb begin
      case (s2_ctl_ff.cls)
         lpf_pkg::CLS_TAGGED: begin
            upd  = (s2_t_ff <= lpf_pkg::TIME_LIMIT);
            emit = upd && s2_ctl_ff.differs && gt;
         end
         lpf_pkg::CLS_SPIN_GE: begin
            upd  = ge;
            emit = ge;
         end
         lpf_pkg::CLS_SPIN_GT: begin
            upd  = gt;
            emit = gt;
         end
         default: begin
            upd  = 1'b0;
            emit = 1'b0;
         end
      endcase
      frame_max_in = (upd && (s2_t_ff > fm_base)) ? s2_t_ff : fm_base;
      s1_valid_in  = adv ? !q_empty : s1_valid_ff;
      s3_valid_in  = adv ? (s2_valid_ff && emit) : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         frame_max_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s3_valid_ff <= s3_valid_in;
         if (adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (move) begin
            frame_max_ff <= frame_max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff     <= q_ctl;
         s1_x_ff       <= q_x;
         s1_y_ff       <= q_y;
         s1_z_ff       <= q_z;
         s1_reflect_ff <= q_reflect;
         s1_sqx_ff     <= $unsigned(sqx);
         s1_sqy_ff     <= $unsigned(sqy);
         s1_sqz_ff     <= $unsigned(sqz);
         s1_t_ff       <= tprod[TP_BITS-1:lpf_pkg::TIME_BITS];
         s2_ctl_ff     <= s1_ctl_ff;
         s2_x_ff       <= s1_x_ff;
         s2_y_ff       <= s1_y_ff;
         s2_z_ff       <= s1_z_ff;
         s2_reflect_ff <= s1_reflect_ff;
         s2_r2_ff      <= R2_BITS'(s1_sqx_ff) + R2_BITS'(s1_sqy_ff) + R2_BITS'(s1_sqz_ff);
         s2_t_ff       <= s1_t_ff;
         s3_x_ff       <= s2_x_ff;
         s3_y_ff       <= s2_y_ff;
         s3_z_ff       <= s2_z_ff;
         s3_reflect_ff <= s2_reflect_ff;
         s3_t_ff       <= s2_t_ff;
         s3_max_ff     <= frame_max_in;
      end
   end

   assign out_x       = s3_x_ff;
   assign out_y       = s3_y_ff;
   assign out_z       = s3_z_ff;
   assign out_reflect = s3_reflect_ff;
   assign time_ms     = s3_t_ff;
   assign max_time_ms = s3_max_ff;

   `LPF_ASSERT_NXT(a_max_hold, clock, reset, !move, $stable(frame_max_ff))
   `LPF_ASSERT_IMP(a_max_covers, clock, reset, s3_valid_ff, max_time_ms >= time_ms)

endmodule

/* src/lidar_point_range_decimation_filter.sv */
// top level of the lidar point range and decimation filter
// depends on lpf_pkg, lpf_front, lpf_queue and lpf_back
//
// points enter on the req_ side: a word is taken at a clock edge with push high and
// full low. kept points leave on the rsp_ side: the oldest waiting word is on the rsp_
// ports while empty is low and is taken at an edge with pop high. dropped points give
// no word. configuration goes through csr_wr_en, csr_index and csr_wdata, one register
// per edge, only while no point is in flight: a user rule the block does not enforce.
// a kept point goes through the queue and the back-end stages. while pop is high and
// no residue rebuild runs, one point a cycle is sustained in both directions; the
// front end classifies each point in the cycle it is taken and the three-stage back
// end (squares and time multiply, range sum, checks) runs one point a cycle.
// a write to the decimation register rebuilds the decimation residues one counter bit
// a cycle, so full stays high until every counter bit has been taken in.
// when a word waits with pop low the result register holds it, the back end stops and
// the four-word queue behind the front end keeps taking points until it fills.
// reset clears the counters, the previous point, the frame maximum and the queue,
// and loads the configuration reset values.
module lidar_point_range_decimation_filter #(
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lpf_pkg::REG_INDEX_BITS-1:0]    csr_index,
   input  logic [lpf_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_frame_start,
   input  logic signed [COORD_BITS-1:0]          req_pos_x,
   input  logic signed [COORD_BITS-1:0]          req_pos_y,
   input  logic signed [COORD_BITS-1:0]          req_pos_z,
   input  logic [lpf_pkg::REFLECT_BITS-1:0]      req_reflect,
   input  logic [lpf_pkg::TIME_BITS-1:0]         req_raw_time,
   input  logic [lpf_pkg::RING_BITS-1:0]         req_ring,
   input  logic [lpf_pkg::TAG_BITS-1:0]          req_tag,
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [COORD_BITS-1:0]          rsp_out_x,
   output logic signed [COORD_BITS-1:0]          rsp_out_y,
   output logic signed [COORD_BITS-1:0]          rsp_out_z,
   output logic [lpf_pkg::REFLECT_BITS-1:0]      rsp_out_reflect,
   output logic [lpf_pkg::TIME_BITS-1:0]         rsp_time_ms,
   output logic [lpf_pkg::TIME_BITS-1:0]         rsp_max_time_ms
);

   localparam int Q_BITS = $bits(lpf_pkg::ctl_type) + 3 * COORD_BITS +
                           lpf_pkg::REFLECT_BITS + lpf_pkg::TIME_BITS;

   lpf_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                              dec_load;
   logic                              busy, accept, q_full, q_empty, q_pop;
   lpf_pkg::ctl_type                  front_ctl, q_ctl;
   logic [Q_BITS-1:0]                 q_wr_data, q_rd_data;
   logic signed [COORD_BITS-1:0]      q_x, q_y, q_z;
   logic [lpf_pkg::REFLECT_BITS-1:0]  q_reflect;
   logic [lpf_pkg::TIME_BITS-1:0]     q_raw_time;

   always_comb begin
      cfg_in   = cfg_ff;
      dec_load = 1'b0;
      if (csr_wr_en) begin
         unique case (lpf_pkg::reg_index_type'(csr_index))
            lpf_pkg::REG_SENSOR_MODE: begin
               cfg_in.sensor_mode = csr_wdata[lpf_pkg::MODE_BITS-1:0];
            end
            lpf_pkg::REG_DECIMATION: begin
               cfg_in.decimation = csr_wdata[lpf_pkg::DEC_BITS-1:0];
               dec_load          = 1'b1;
            end
            lpf_pkg::REG_BLIND_RANGE_SQ: begin
               cfg_in.blind_range_sq = csr_wdata[lpf_pkg::BLIND_BITS-1:0];
            end
            lpf_pkg::REG_LINE_COUNT: begin
               cfg_in.line_count = csr_wdata[lpf_pkg::LINE_BITS-1:0];
            end
            lpf_pkg::REG_TIME_MULT: begin
               cfg_in.time_mult = csr_wdata[lpf_pkg::TIME_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_mode    <= lpf_pkg::RST_SENSOR_MODE;
         cfg_ff.decimation     <= lpf_pkg::RST_DECIMATION;
         cfg_ff.blind_range_sq <= lpf_pkg::RST_BLIND;
         cfg_ff.line_count     <= lpf_pkg::RST_LINE_COUNT;
         cfg_ff.time_mult      <= lpf_pkg::RST_TIME_MULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign full   = q_full || busy;
   assign accept = push && !full;

   lpf_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .dec_load    (dec_load),
      .accept      (accept),
      .frame_start (req_frame_start),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .pos_z       (req_pos_z),
      .ring        (req_ring),
      .tag         (req_tag),
      .busy        (busy),
      .ctl         (front_ctl)
   );

   assign q_wr_data = {front_ctl, req_pos_x, req_pos_y, req_pos_z, req_reflect, req_raw_time};

   lpf_queue #(
      .DATA_BITS (Q_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (q_wr_data),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   assign {q_ctl, q_x, q_y, q_z, q_reflect, q_raw_time} = q_rd_data;

   lpf_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_ctl       (q_ctl),
      .q_x         (q_x),
      .q_y         (q_y),
      .q_z         (q_z),
      .q_reflect   (q_reflect),
      .q_raw_time  (q_raw_time),
      .empty       (empty),
      .pop         (pop),
      .out_x       (rsp_out_x),
      .out_y       (rsp_out_y),
      .out_z       (rsp_out_z),
      .out_reflect (rsp_out_reflect),
      .time_ms     (rsp_time_ms),
      .max_time_ms (rsp_max_time_ms)
   );

endmodule
